// ===== rtl/bep_pkg.sv =====
// Shared types and constants for the bencode event parser.
`timescale 1ns / 1ps
package bep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef enum logic [3:0] {
    KIND_INT       = 4'd0,
    KIND_STR_HDR   = 4'd1,
    KIND_STR_BYTE  = 4'd2,
    KIND_LIST_OPEN = 4'd3,
    KIND_LIST_END  = 4'd4,
    KIND_DICT_OPEN = 4'd5,
    KIND_DICT_END  = 4'd6,
    KIND_DONE      = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INVALID  = 2'd1,
    ERR_TOO_DEEP = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    PH_ITEM  = 3'd0,
    PH_KEY   = 3'd1,
    PH_INT   = 3'd2,
    PH_LEN   = 3'd3,
    PH_BYTES = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERROR = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CT_NONE = 2'd0,
    CT_LIST = 2'd1,
    CT_DICT = 2'd2
  } ctype_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] int_value;
    logic [31:0]        str_length;
    logic [7:0]         content_byte;
    logic               is_key;
    logic [5:0]         nest_level;
    err_t               err_code;
    logic               last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] n;
    out_beat_t  first;
    out_beat_t  second;
  } ev_push_t;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic out_beat_t mk_ev(kind_t k, logic [63:0] iv, logic [31:0] sl,
                                      logic [7:0] cb, logic key, logic [5:0] lvl,
                                      err_t ec);
    out_beat_t e;
    e.kind         = k;
    e.int_value    = iv;
    e.str_length   = sl;
    e.content_byte = cb;
    e.is_key       = key;
    e.nest_level   = lvl;
    e.err_code     = ec;
    e.last_of_run  = 1'b0;
    return e;
  endfunction

endpackage

// ===== rtl/bencode_event_parser_core.sv =====
// Top level of the bencode event parser.
// The events of an accepted byte are registered in the event queue, in order.
// Takes one byte per cycle while each byte yields at most one event and out_stall
// is low; output drains one event per cycle, unless stalled, via a four-entry queue.
// Reset: synchronous rst clears parse state and queue; no clearing pass,
// the container stack memory is written before it is read.
`timescale 1ns / 1ps
module bencode_event_parser_core import bep_pkg::*; #(
  parameter int MAX_DEPTH   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
  ev_push_t push;
  logic     full;

  assign in_stall = full;

  bep_parser #(.MAX_DEPTH(MAX_DEPTH), .LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk (clk),
    .rst (rst),
    .take(in_valid && !full),
    .beat(in_data),
    .push(push)
  );

  bep_evq u_evq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .valid(out_valid),
    .stall(out_stall),
    .data (out_data)
  );
endmodule

// ===== rtl/bep_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bep_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/bep_parser.sv =====
// Parse state, container stack and per-byte event generation.
`timescale 1ns / 1ps
module bep_parser import bep_pkg::*; #(
  parameter int MAX_DEPTH   = 32,
  parameter int LENGTH_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_beat_t beat,
  output ev_push_t push
);
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH > 1 ? MAX_DEPTH : 2);
  localparam int LB = LENGTH_BITS;

  phase_t          phase, phase_next;
  logic [63:0]     int_acc, int_acc_next;
  logic            int_neg, int_neg_next;
  logic            have_digit, have_digit_next;
  logic            first_zero, first_zero_next;
  logic [LB-1:0]   len_acc, len_acc_next;
  logic [LB-1:0]   remaining, remaining_next;
  logic            str_key, str_key_next;
  logic [DW-1:0]   depth, depth_next;
  ctype_t          top, top_next;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [1:0]      wr_data;
  logic [AW-1:0]   rd_addr;
  logic [1:0]      under;
  logic [DW-1:0]   rd_full;

  bep_ram #(.WIDTH(2), .DEPTH(MAX_DEPTH)) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(under)
  );

  always_comb begin
    logic [7:0]      c;
    logic            is_digit;
    logic [3:0]      d;
    logic            as_key;
    ctype_t          top_eff;
    logic            do_open, do_close, done_chk, was_key;
    ctype_t          oct, cct, tafter;
    logic [67:0]     ip, ilim;
    logic [LB+3:0]   lp, lmax;
    logic [3:0]      cv;
    out_beat_t       ce [4];
    logic [1:0]      n;
    out_beat_t       e0, e1;

    c        = beat.data_byte;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = 4'(c - CH_ZERO);
    as_key   = (phase == PH_KEY);
    top_eff  = (depth == '0) ? CT_NONE : top;
    do_open  = 1'b0;
    do_close = 1'b0;
    done_chk = 1'b0;
    was_key  = 1'b0;
    oct      = CT_LIST;
    cct      = CT_LIST;
    tafter   = top_eff;
    ip       = {1'b0, int_acc, 3'b000} + {3'b000, int_acc, 1'b0} + 68'(d);
    ilim     = int_neg ? (68'd1 << 63) : ((68'd1 << 63) - 68'd1);
    lp       = {1'b0, len_acc, 3'b000} + {3'b000, len_acc, 1'b0} + (LB+4)'(d);
    lmax     = {4'b0000, {LB{1'b1}}};
    cv       = '0;
    for (int i = 0; i < 4; i++) begin
      ce[i] = '0;
    end

    phase_next      = phase;
    int_acc_next    = int_acc;
    int_neg_next    = int_neg;
    have_digit_next = have_digit;
    first_zero_next = first_zero;
    len_acc_next    = len_acc;
    remaining_next  = remaining;
    str_key_next    = str_key;
    depth_next      = depth;
    top_next        = top;
    wr_en           = 1'b0;
    wr_addr         = depth[AW-1:0];
    wr_data         = CT_LIST;

    if (take) begin
      unique case (phase)
        PH_ITEM, PH_KEY: begin
          if (is_digit) begin
            len_acc_next = LB'(d);
            str_key_next = as_key;
            phase_next   = PH_LEN;
          end else if (as_key) begin
            if (c == CH_E) begin
              do_close = 1'b1;
              cct      = CT_DICT;
            end else begin
              cv[0] = 1'b1;
              ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
              phase_next = PH_ERROR;
            end
          end else if (c == CH_I) begin
            int_acc_next    = '0;
            int_neg_next    = 1'b0;
            have_digit_next = 1'b0;
            first_zero_next = 1'b0;
            phase_next      = PH_INT;
          end else if (c == CH_L) begin
            do_open = 1'b1;
            oct     = CT_LIST;
          end else if (c == CH_D) begin
            do_open = 1'b1;
            oct     = CT_DICT;
          end else if (c == CH_E && top_eff == CT_LIST) begin
            do_close = 1'b1;
            cct      = CT_LIST;
          end else begin
            cv[0] = 1'b1;
            ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
            phase_next = PH_ERROR;
          end
        end
        PH_INT: begin
          if (c == CH_MINUS) begin
            if (!have_digit && !int_neg) begin
              int_neg_next = 1'b1;
            end else begin
              cv[0] = 1'b1;
              ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
              phase_next = PH_ERROR;
            end
          end else if (is_digit) begin
            if (first_zero || (d == 4'd0 && !have_digit && int_neg) || (ip > ilim)) begin
              cv[0] = 1'b1;
              ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
              phase_next = PH_ERROR;
            end else begin
              int_acc_next    = ip[63:0];
              have_digit_next = 1'b1;
              if (!have_digit && d == 4'd0) begin
                first_zero_next = 1'b1;
              end
            end
          end else if (c == CH_E && have_digit) begin
            cv[0] = 1'b1;
            ce[0] = mk_ev(KIND_INT, int_neg ? (64'd0 - int_acc) : int_acc, '0, '0,
                          1'b0, 6'(depth), ERR_NONE);
            int_acc_next    = '0;
            int_neg_next    = 1'b0;
            have_digit_next = 1'b0;
            first_zero_next = 1'b0;
            done_chk        = 1'b1;
          end else begin
            cv[0] = 1'b1;
            ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
            phase_next = PH_ERROR;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            if (lp > lmax) begin
              cv[0] = 1'b1;
              ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
              phase_next = PH_ERROR;
            end else begin
              len_acc_next = lp[LB-1:0];
            end
          end else if (c == CH_COLON) begin
            cv[0] = 1'b1;
            ce[0] = mk_ev(KIND_STR_HDR, '0, 32'(len_acc), '0, str_key, 6'(depth),
                          ERR_NONE);
            remaining_next = len_acc;
            len_acc_next   = '0;
            if (len_acc == '0) begin
              done_chk = 1'b1;
              was_key  = str_key;
            end else begin
              phase_next = PH_BYTES;
            end
          end else begin
            cv[0] = 1'b1;
            ce[0] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_INVALID);
            phase_next = PH_ERROR;
          end
        end
        PH_BYTES: begin
          cv[0] = 1'b1;
          ce[0] = mk_ev(KIND_STR_BYTE, '0, '0, c, str_key, 6'(depth), ERR_NONE);
          remaining_next = remaining - LB'(1);
          if (remaining == LB'(1)) begin
            done_chk = 1'b1;
            was_key  = str_key;
          end
        end
        default: begin
        end
      endcase

      if (do_open) begin
        if (depth >= DW'(MAX_DEPTH)) begin
          cv[1] = 1'b1;
          ce[1] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth), ERR_TOO_DEEP);
          phase_next = PH_ERROR;
        end else begin
          depth_next = depth + DW'(1);
          top_next   = oct;
          wr_en      = 1'b1;
          wr_data    = oct;
          cv[1] = 1'b1;
          ce[1] = mk_ev((oct == CT_LIST) ? KIND_LIST_OPEN : KIND_DICT_OPEN, '0, '0, '0,
                        1'b0, 6'(depth + DW'(1)), ERR_NONE);
          phase_next = (oct == CT_DICT) ? PH_KEY : PH_ITEM;
        end
      end

      if (do_close) begin
        depth_next = depth - DW'(1);
        top_next   = ctype_t'(under);
        tafter     = ctype_t'(under);
        cv[1] = 1'b1;
        ce[1] = mk_ev((cct == CT_LIST) ? KIND_LIST_END : KIND_DICT_END, '0, '0, '0,
                      1'b0, 6'(depth - DW'(1)), ERR_NONE);
        done_chk = 1'b1;
      end

      if (done_chk) begin
        if (depth_next == '0) begin
          cv[2] = 1'b1;
          ce[2] = mk_ev(KIND_DONE, '0, '0, '0, 1'b0, '0, ERR_NONE);
          phase_next = PH_DONE;
        end else begin
          phase_next = (tafter == CT_DICT && !was_key) ? PH_KEY : PH_ITEM;
        end
      end

      if (beat.end_of_buffer) begin
        if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
          cv[3] = 1'b1;
          ce[3] = mk_ev(KIND_ERROR, '0, '0, '0, 1'b0, 6'(depth_next), ERR_INVALID);
        end
        phase_next      = PH_ITEM;
        int_acc_next    = '0;
        int_neg_next    = 1'b0;
        have_digit_next = 1'b0;
        first_zero_next = 1'b0;
        len_acc_next    = '0;
        remaining_next  = '0;
        str_key_next    = 1'b0;
        depth_next      = '0;
      end
    end

    n  = 2'd0;
    e0 = '0;
    e1 = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        if (n == 2'd0) begin
          e0 = ce[i];
          n  = 2'd1;
        end else if (n == 2'd1) begin
          e1 = ce[i];
          n  = 2'd2;
        end
      end
    end
    if (n == 2'd2) begin
      e1.last_of_run = 1'b1;
    end else if (n == 2'd1) begin
      e0.last_of_run = 1'b1;
    end
    push.n      = n;
    push.first  = e0;
    push.second = e1;

    rd_full = depth_next - DW'(2);
    rd_addr = rd_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ITEM;
      int_acc    <= '0;
      int_neg    <= 1'b0;
      have_digit <= 1'b0;
      first_zero <= 1'b0;
      len_acc    <= '0;
      remaining  <= '0;
      str_key    <= 1'b0;
      depth      <= '0;
      top        <= CT_NONE;
    end else begin
      phase      <= phase_next;
      int_acc    <= int_acc_next;
      int_neg    <= int_neg_next;
      have_digit <= have_digit_next;
      first_zero <= first_zero_next;
      len_acc    <= len_acc_next;
      remaining  <= remaining_next;
      str_key    <= str_key_next;
      depth      <= depth_next;
      top        <= top_next;
    end
  end
endmodule

// ===== rtl/bep_evq.sv =====
// Four-entry event queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps
module bep_evq import bep_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ev_push_t  push,
  output logic      full,
  output logic      valid,
  input  logic      stall,
  output out_beat_t data
);
  out_beat_t  slot [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic       pop;

  assign pop   = valid && !stall;
  assign valid = (count != 3'd0);
  assign full  = (count > 3'd2);
  assign data  = slot[head];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slot[tail] <= push.first;
    end
    if (push.n == 2'd2) begin
      slot[tail + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push.n;
      head  <= head + {1'b0, pop};
      count <= count + {1'b0, push.n} - {2'b00, pop};
    end
  end
endmodule

// ===== rtl/bep_checker.sv =====
// Port-level checks for the bencode event parser, bound to the top level.
`timescale 1ns / 1ps
module bep_checker import bep_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("beat after reset");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.kind == KIND_ERROR) == (out_data.err_code != ERR_NONE)))
    else $error("error code mismatch");

  a_key_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_key |->
      (out_data.kind == KIND_STR_HDR || out_data.kind == KIND_STR_BYTE))
    else $error("key flag on non-string beat");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending beat");
endmodule

bind bencode_event_parser_core bep_checker u_bep_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== tb/tb_bencode_event_parser_core.sv =====
// Testbench for the bencode event parser: random and directed buffers, scoreboard check.
`timescale 1ns / 1ps
module tb_bencode_event_parser_core;
  import bep_pkg::*;

  localparam int DEPTH_MAX = 32;
  localparam int LEN_BITS  = 32;
  localparam int IDLE_LIMIT = 20000;

  class event_scoreboard;
    phase_t      phase;
    logic [63:0] int_acc;
    bit          int_neg;
    int unsigned int_digits;
    bit          lead_zero;
    logic [63:0] len_acc;
    logic [63:0] bytes_left;
    bit          str_key;
    int unsigned depth;
    ctype_t      kinds [DEPTH_MAX];
    out_beat_t   pending_events [$];
    out_beat_t   step_events [$];
    int          error_count;
    int          event_count;

    function new();
      error_count = 0;
      event_count = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_ITEM;
      int_acc = 0;
      int_neg = 0;
      int_digits = 0;
      lead_zero = 0;
      len_acc = 0;
      bytes_left = 0;
      str_key = 0;
      depth = 0;
    endfunction

    function void emit(kind_t k, logic [63:0] iv, logic [31:0] sl, logic [7:0] cb,
                       bit key, err_t ec);
      out_beat_t e;
      if (step_events.size() >= 2) return;
      e.kind = k;
      e.int_value = iv;
      e.str_length = sl;
      e.content_byte = cb;
      e.is_key = key;
      e.nest_level = depth[5:0];
      e.err_code = ec;
      e.last_of_run = 0;
      step_events.push_back(e);
    endfunction

    function void fail(err_t ec);
      emit(KIND_ERROR, 0, 0, 0, 0, ec);
      phase = PH_ERROR;
    endfunction

    function ctype_t top();
      if (depth == 0 || depth > DEPTH_MAX) return CT_NONE;
      return kinds[depth-1];
    endfunction

    function void item_done(bit was_key);
      if (depth == 0) begin
        emit(KIND_DONE, 0, 0, 0, 0, ERR_NONE);
        phase = PH_DONE;
        return;
      end
      phase = (top() == CT_DICT && !was_key) ? PH_KEY : PH_ITEM;
    endfunction

    function void open_ct(ctype_t ct);
      if (depth >= DEPTH_MAX) begin
        fail(ERR_TOO_DEEP);
        return;
      end
      kinds[depth] = ct;
      depth++;
      emit(ct == CT_LIST ? KIND_LIST_OPEN : KIND_DICT_OPEN, 0, 0, 0, 0, ERR_NONE);
      phase = (ct == CT_DICT) ? PH_KEY : PH_ITEM;
    endfunction

    function void close_ct(ctype_t ct);
      depth--;
      emit(ct == CT_LIST ? KIND_LIST_END : KIND_DICT_END, 0, 0, 0, 0, ERR_NONE);
      item_done(0);
    endfunction

    function void start_item(logic [7:0] c, bit as_key);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        len_acc = c - CH_ZERO;
        str_key = as_key;
        phase = PH_LEN;
      end else if (as_key) begin
        if (c == CH_E) close_ct(CT_DICT);
        else fail(ERR_INVALID);
      end else if (c == CH_I) begin
        int_acc = 0;
        int_neg = 0;
        int_digits = 0;
        lead_zero = 0;
        phase = PH_INT;
      end else if (c == CH_L) open_ct(CT_LIST);
      else if (c == CH_D) open_ct(CT_DICT);
      else if (c == CH_E && top() == CT_LIST) close_ct(CT_LIST);
      else fail(ERR_INVALID);
    endfunction

    function void int_char(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] lim;
      if (c == CH_MINUS) begin
        if (int_digits == 0 && !int_neg) int_neg = 1;
        else fail(ERR_INVALID);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        lim = int_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (lead_zero || (d == 0 && int_digits == 0 && int_neg)) begin
          fail(ERR_INVALID);
          return;
        end
        if (int_acc > (lim - d) / 10) begin
          fail(ERR_INVALID);
          return;
        end
        int_acc = int_acc * 10 + d;
        if (int_digits == 0 && d == 0) lead_zero = 1;
        if (int_digits < 31) int_digits++;
      end else if (c == CH_E && int_digits != 0) begin
        emit(KIND_INT, int_neg ? -int_acc : int_acc, 0, 0, 0, ERR_NONE);
        int_acc = 0;
        int_neg = 0;
        int_digits = 0;
        lead_zero = 0;
        item_done(0);
      end else fail(ERR_INVALID);
    endfunction

    function void len_char(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] maxlen;
      maxlen = (64'd1 << LEN_BITS) - 1;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        if (len_acc > (maxlen - d) / 10) begin
          fail(ERR_INVALID);
          return;
        end
        len_acc = len_acc * 10 + d;
      end else if (c == CH_COLON) begin
        emit(KIND_STR_HDR, 0, len_acc[31:0], 0, str_key, ERR_NONE);
        bytes_left = len_acc;
        len_acc = 0;
        if (bytes_left == 0) item_done(str_key);
        else phase = PH_BYTES;
      end else fail(ERR_INVALID);
    endfunction

    function void note_input(in_beat_t b);
      step_events.delete();
      case (phase)
        PH_ITEM: start_item(b.data_byte, 0);
        PH_KEY: start_item(b.data_byte, 1);
        PH_INT: int_char(b.data_byte);
        PH_LEN: len_char(b.data_byte);
        PH_BYTES: begin
          emit(KIND_STR_BYTE, 0, 0, b.data_byte, str_key, ERR_NONE);
          bytes_left--;
          if (bytes_left == 0) item_done(str_key);
        end
        default: ;
      endcase
      if (b.end_of_buffer) begin
        if (phase != PH_DONE && phase != PH_ERROR) fail(ERR_INVALID);
        clear();
      end
      if (step_events.size() > 0) step_events[step_events.size()-1].last_of_run = 1;
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endfunction

    function void check_event(out_beat_t got);
      out_beat_t exp;
      event_count++;
      if (pending_events.size() == 0) begin
        $error("unexpected event kind=%0d", got.kind);
        error_count++;
        return;
      end
      exp = pending_events.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind); error_count++;
      end
      if (got.int_value !== exp.int_value) begin
        $error("int_value: expected %0d, got %0d", exp.int_value, got.int_value);
        error_count++;
      end
      if (got.str_length !== exp.str_length) begin
        $error("str_length: expected %0d, got %0d", exp.str_length, got.str_length);
        error_count++;
      end
      if (got.content_byte !== exp.content_byte) begin
        $error("content_byte: expected %0h, got %0h", exp.content_byte, got.content_byte);
        error_count++;
      end
      if (got.is_key !== exp.is_key) begin
        $error("is_key: expected %0d, got %0d", exp.is_key, got.is_key); error_count++;
      end
      if (got.nest_level !== exp.nest_level) begin
        $error("nest_level: expected %0d, got %0d", exp.nest_level, got.nest_level);
        error_count++;
      end
      if (got.err_code !== exp.err_code) begin
        $error("err_code: expected %0d, got %0d", exp.err_code, got.err_code);
        error_count++;
      end
      if (got.last_of_run !== exp.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", exp.last_of_run, got.last_of_run);
        error_count++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  bencode_event_parser_core #(.MAX_DEPTH(DEPTH_MAX), .LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  event_scoreboard sb;
  byte unsigned buf_bytes [$];
  int  beats_sent;
  int  idle_cycles;
  bit  quiet;
  bit  hold_long;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_event(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver side: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_stall = 0;
    @(negedge clk);
    while (1) begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
      @(negedge clk);
    end
  end

  task automatic send_beat(byte unsigned b, bit eob);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_data <= '{data_byte: b, end_of_buffer: eob};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_bytes.size(); i++)
      send_beat(buf_bytes[i], i == buf_bytes.size() - 1);
    in_valid <= 0;
    buf_bytes.delete();
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) buf_bytes.push_back(s[i]);
  endtask

  task automatic gen_int();
    longint unsigned v;
    v = {$urandom, $urandom} >> $urandom_range(0, 63);
    buf_bytes.push_back(CH_I);
    if ($urandom_range(0, 2) == 0 && v != 0) buf_bytes.push_back(CH_MINUS);
    put_str($sformatf("%0d", v >> 1));
    buf_bytes.push_back(CH_E);
  endtask

  task automatic gen_str();
    int n;
    n = $urandom_range(0, 6);
    put_str($sformatf("%0d:", n));
    repeat (n) buf_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic gen_item(int lvl);
    int n;
    case ($urandom_range(0, 3))
      0: gen_int();
      1: gen_str();
      2: begin
        buf_bytes.push_back(CH_L);
        n = (lvl > 3) ? 0 : $urandom_range(0, 3);
        repeat (n) gen_item(lvl + 1);
        buf_bytes.push_back(CH_E);
      end
      default: begin
        buf_bytes.push_back(CH_D);
        n = (lvl > 3) ? 0 : $urandom_range(0, 3);
        repeat (n) begin
          gen_str();
          gen_item(lvl + 1);
        end
        buf_bytes.push_back(CH_E);
      end
    endcase
  endtask

  task automatic corrupt();
    int p;
    if (buf_bytes.size() == 0) return;
    p = $urandom_range(0, buf_bytes.size() - 1);
    case ($urandom_range(0, 2))
      0: buf_bytes[p] = $urandom_range(0, 255);
      1: buf_bytes = buf_bytes[0:p];
      default: repeat ($urandom_range(1, 4)) buf_bytes.push_back($urandom_range(0, 255));
    endcase
  endtask

  task automatic run_directed();
    string cases [$];
    cases = '{"i0e", "i-1e", "i9223372036854775807e", "i-9223372036854775808e",
              "i9223372036854775808e", "ie", "i-e", "i-0e", "i03e", "i-03e",
              "4294967295:", "4294967296:", "0003:abc", "0:xyz", "le", "de",
              "d3:keyi5ee", "di1ei2ee", "d1:ae", "l1:ae", "li1e", "e", "x",
              "i12-e", "ld1:a0:ee"};
    foreach (cases[i]) begin
      put_str(cases[i]);
      send_buffer();
    end
    repeat (DEPTH_MAX + 1) buf_bytes.push_back(CH_L);
    send_buffer();
    repeat (DEPTH_MAX) buf_bytes.push_back(CH_D);
    send_buffer();
    buf_bytes.push_back(8'hFF);
    buf_bytes.push_back(8'h00);
    send_buffer();
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    quiet = 0;
    hold_long = 0;
    beats_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    run_directed();
    while (beats_sent < 2000) begin
      gen_item(0);
      if ($urandom_range(0, 4) == 0) corrupt();
      else if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3))
        buf_bytes.push_back($urandom_range(0, 255));
      if (beats_sent > 600 && beats_sent < 700 && !hold_long) hold_long = 1;
      if (beats_sent > 1700) quiet = 1;
      send_buffer();
    end
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes, checked %0d events: integers, strings, nested lists and dicts,",
             beats_sent, sb.event_count);
    $display("malformed, truncated and over-deep buffers.");
    if (sb.error_count == 0 && sb.pending_events.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bep_pkg.sv
rtl/bep_ram.sv
rtl/bep_parser.sv
rtl/bep_evq.sv
rtl/bencode_event_parser_core.sv
rtl/bep_checker.sv
tb/tb_bencode_event_parser_core.sv
